/* rtl/core/stdu_pkg.sv */
// shared constants, prime table, types and helpers for the smoothness trial division unit
package stdu_pkg;

	localparam int VALUE_W       = 64;
	localparam int PRIME_W       = 9;
	localparam int EXP_W         = 6;
	localparam int IDX_W         = 6;
	localparam int BOUND_W       = 9;
	localparam int DIGIT_W       = 4;
	localparam int MAX_BOUND_DEF = 256;
	localparam int PRIME_SLOTS   = 64;

	localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(256);

	typedef logic [PRIME_W-1:0] prime_tab_t [PRIME_SLOTS];

	// primes up to 256 in ascending order, unused slots hold zero
	localparam prime_tab_t PRIME_TAB = '{
		9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
		9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
		9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
		9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
		9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
		9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
		9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd0,   9'd0,
		9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0
	};

	// number of primes not above the given bound
	function automatic int count_primes(input int bound);
		int n;
		n = 0;
		for (int i = 0; i < PRIME_SLOTS; i++) begin
			if (PRIME_TAB[i] != '0 && int'(PRIME_TAB[i]) <= bound) begin
				n++;
			end
		end
		return n;
	endfunction

	typedef struct packed {
		logic done;
		logic rem_zero;
	} div_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_TRIAL,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

/* rtl/core/stdu_digit_div.sv */
// digit-serial divider of a 64-bit magnitude by a small prime
module stdu_digit_div import stdu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [VALUE_W-1:0] dividend,
	input  logic [PRIME_W-1:0] divisor,
	output logic [VALUE_W-1:0] quotient,
	output div_stat_t          stat
);

	localparam int STEPS = VALUE_W / DIGIT_W;
	localparam int CNT_W = $clog2(STEPS);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

	logic [VALUE_W-1:0] quo_q;
	logic [PRIME_W-1:0] rem_q;
	logic [PRIME_W-1:0] div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               run_q;
	logic               done_q;

	logic [VALUE_W-1:0] quo_nxt;
	logic [PRIME_W-1:0] rem_nxt;

	// one restoring step per bit, DIGIT_W bits per cycle
	always_comb begin
		logic [PRIME_W:0]   t;
		logic [PRIME_W-1:0] r;
		logic [VALUE_W-1:0] q;
		r = rem_q;
		q = quo_q;
		t = '0;
		for (int i = 0; i < DIGIT_W; i++) begin
			t = {r, q[VALUE_W-1]};
			q = {q[VALUE_W-2:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				t    = t - {1'b0, div_q};
				q[0] = 1'b1;
			end
			r = t[PRIME_W-1:0];
		end
		quo_nxt = q;
		rem_nxt = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (run_q) begin
			quo_q <= quo_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign quotient      = quo_q;
	assign stat.done     = done_q;
	assign stat.rem_zero = (rem_q == '0);

endmodule

/* rtl/core/smoothness_trial_division_unit.sv */
// top level of the smoothness trial division unit
//
// channel   direction  handshake                 payload
// request   in         start, accepted if !busy  value
// config    in         bound_we                  bound_wdata
// result    out        result_strobe, no stall   entry_index, prime, exponent, smooth, last
//
// a prime whose cofactor is already 0 or 1 closes in the trial state without a division, otherwise
// each division attempt is launched from the trial state, run in the divider
// (4 quotient bits per cycle over 64 bits) and its outcome taken in the divide state
// a prime is divided again while the remainder is zero; the default bound admits 54 primes
// the exponent vector is emitted one entry per cycle after all divisions,
// since smooth is only known at the end; the receiver cannot stall
// reset clears the control state and sets the bound to 256
module smoothness_trial_division_unit import stdu_pkg::*; #(
	parameter int MAX_BOUND = MAX_BOUND_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic signed [VALUE_W-1:0] value,
	input  logic                      bound_we,
	input  logic [BOUND_W-1:0]        bound_wdata,
	output logic                      result_strobe,
	output logic [IDX_W-1:0]          entry_index,
	output logic signed [PRIME_W-1:0] prime,
	output logic [EXP_W-1:0]          exponent,
	output logic                      smooth,
	output logic                      last
);

	// primes available under the elaborated bound
	localparam int NPRIMES = count_primes(MAX_BOUND);
	localparam int PIDX_W  = $clog2(NPRIMES + 1);
	localparam int AW      = $clog2(NPRIMES);

	state_t state_q, state_nxt;

	logic [BOUND_W-1:0] bound_q;
	logic               neg_q;
	logic [VALUE_W-1:0] mag_q;
	logic [PIDX_W-1:0]  pidx_q;   // current prime, ends as the count of primes used
	logic [EXP_W-1:0]   exp_q;    // running multiplicity of the current prime
	logic [PIDX_W-1:0]  ent_q;    // entry being emitted

	// exponent store, one entry per prime
	logic [EXP_W-1:0] exp_mem [NPRIMES];
	logic [EXP_W-1:0] rd_q;

	// output registers
	logic               strobe_q;
	logic [IDX_W-1:0]   entry_index_q;
	logic [PRIME_W-1:0] prime_q;
	logic [EXP_W-1:0]   exponent_q;
	logic               smooth_q;
	logic               last_q;

	logic [PRIME_W-1:0] prime_cur;
	logic               in_range;
	logic               mag_small;
	logic               last_ent;
	logic               div_start;
	logic               exp_we;
	logic [VALUE_W-1:0] div_quo;
	div_stat_t          div_stat;

	// prime under trial and whether it still lies within the bound
	assign prime_cur = PRIME_TAB[6'(pidx_q)];
	assign in_range  = (pidx_q < PIDX_W'(NPRIMES)) && (prime_cur <= bound_q);
	// a cofactor of 0 or 1 takes no division
	assign mag_small = (mag_q[VALUE_W-1:1] == '0);
	assign last_ent  = (ent_q == pidx_q);

	stdu_digit_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mag_q),
		.divisor  (prime_cur),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_TRIAL;
				end
			end
			ST_TRIAL: begin
				if (!in_range) begin
					state_nxt = ST_EMIT;
				end else if (!mag_small) begin
					state_nxt = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					state_nxt = ST_TRIAL;
				end
			end
			ST_EMIT: begin
				if (last_ent) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		div_start = 1'b0;
		exp_we    = 1'b0;
		busy      = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
			end
			ST_TRIAL: begin
				div_start = in_range && !mag_small;
				exp_we    = in_range && mag_small;
			end
			ST_DIV: begin
				// a nonzero remainder closes this prime
				exp_we = div_stat.done && !div_stat.rem_zero;
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bound_q  <= BOUND_RESET;
			strobe_q <= 1'b0;
			pidx_q   <= '0;
			exp_q    <= '0;
			ent_q    <= '0;
		end else begin
			state_q  <= state_nxt;
			strobe_q <= (state_q == ST_EMIT);
			if (bound_we) begin
				bound_q <= bound_wdata;
			end
			if (state_q == ST_IDLE && start) begin
				pidx_q <= '0;
				exp_q  <= '0;
				ent_q  <= '0;
			end
			if (exp_we) begin
				pidx_q <= pidx_q + 1'b1;
				exp_q  <= '0;
			end else if (state_q == ST_DIV && div_stat.done && div_stat.rem_zero) begin
				exp_q <= exp_q + 1'b1;
			end
			if (state_q == ST_EMIT) begin
				ent_q <= ent_q + 1'b1;
			end
		end
	end

	// magnitude capture and cofactor update; most negative value wraps to 2^63
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			neg_q <= value[VALUE_W-1];
			mag_q <= value[VALUE_W-1] ? VALUE_W'(-value) : VALUE_W'(value);
		end else if (state_q == ST_DIV && div_stat.done && div_stat.rem_zero) begin
			mag_q <= div_quo;
		end
	end

	// exponent store: written as each prime closes, read one entry ahead of emission
	always_ff @(posedge clk) begin
		if (exp_we) begin
			exp_mem[pidx_q[AW-1:0]] <= exp_q;
		end
		if (state_q == ST_EMIT && ent_q < PIDX_W'(NPRIMES)) begin
			rd_q <= exp_mem[ent_q[AW-1:0]];
		end
	end

	// result registers, entry zero carries the sign
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			entry_index_q <= IDX_W'(ent_q);
			smooth_q      <= (mag_q == VALUE_W'(1));
			last_q        <= last_ent;
			if (ent_q == '0) begin
				prime_q    <= '1;
				exponent_q <= EXP_W'(neg_q);
			end else begin
				prime_q    <= PRIME_TAB[6'(ent_q - 1'b1)];
				exponent_q <= rd_q;
			end
		end
	end

	assign result_strobe = strobe_q;
	assign entry_index   = entry_index_q;
	assign prime         = signed'(prime_q);
	assign exponent      = exponent_q;
	assign smooth        = smooth_q;
	assign last          = last_q;

endmodule
